/* src/eldc_pkg.sv */
// Shared constants, types and helpers for the edge list degree counter.
// No dependencies; imported by the sequencer, the top level and the checker.
package eldc_pkg;

  // Degree store geometry
  localparam int NODE_DEPTH  = 1024;
  localparam int DEGREE_BITS = 16;
  localparam int ADDR_BITS   = $clog2(NODE_DEPTH);

  // Fixed field widths of the ports
  localparam int ID_BITS    = 10;
  localparam int TOTAL_BITS = 11;
  localparam int COUNT_BITS = 16;

  // Request codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Degree memory access from the sequencer
  typedef struct packed {
    logic                   we;
    logic [ADDR_BITS-1:0]   waddr;
    logic [DEGREE_BITS-1:0] wdata;
    logic [ADDR_BITS-1:0]   raddr;
  } mem_req_t;

  // Node id has an entry in the degree store
  function automatic logic id_in_store(input logic [ID_BITS-1:0] id);
    return (32'(id) < NODE_DEPTH);
  endfunction

  // Store address of a node id
  function automatic logic [ADDR_BITS-1:0] id_addr(input logic [ID_BITS-1:0] id);
    return ADDR_BITS'(id);
  endfunction

  // Stored degree clipped to the reported width
  function automatic logic [COUNT_BITS-1:0] report_degree(
    input logic [DEGREE_BITS-1:0] deg
  );
    logic [31:0] d32;
    d32 = 32'(deg);
    if (d32 > 32'h0000_FFFF) begin
      return '1;
    end
    return d32[COUNT_BITS-1:0];
  endfunction

endpackage

/* src/eldc_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module eldc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/eldc_seq.sv */
// Sequencer: clearing pass, read-modify-write of endpoint degrees,
// edge/node counters and the result word register. Uses eldc_pkg.
module eldc_seq import eldc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_req_type,
  input  logic [ID_BITS-1:0]     in_first_node,
  input  logic [ID_BITS-1:0]     in_second_node,
  input  logic [ID_BITS-1:0]     in_query_node,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COUNT_BITS-1:0]  out_node_degree,
  output logic [TOTAL_BITS-1:0]  out_node_total,
  output logic [COUNT_BITS-1:0]  out_edge_total,
  output logic                   out_node_in_range,
  output mem_req_t               mem_req,
  input  logic [DEGREE_BITS-1:0] mem_rdata
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_A,
    ST_UPD_B,
    ST_QUERY
  } state_t;

  state_t                 state_r;
  logic [ADDR_BITS-1:0]   clr_cnt_r;
  logic [ID_BITS-1:0]     a_r, b_r, q_r;
  logic [ID_BITS-1:0]     largest_r, largest_nxt;
  logic [COUNT_BITS-1:0]  edges_r;
  logic                   out_valid_r;
  logic [COUNT_BITS-1:0]  out_degree_r;
  logic [TOTAL_BITS-1:0]  out_total_r;
  logic [COUNT_BITS-1:0]  out_edges_r;
  logic                   out_range_r;
  logic [DEGREE_BITS-1:0] deg_inc;
  logic [TOTAL_BITS-1:0]  total;
  logic                   out_free;
  logic                   out_load;

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_node_degree   = out_degree_r;
  assign out_node_total    = out_total_r;
  assign out_edge_total    = out_edges_r;
  assign out_node_in_range = out_range_r;

  // saturating increment of the word just read
  assign deg_inc  = (mem_rdata == '1) ? mem_rdata : mem_rdata + 1'b1;
  assign total    = TOTAL_BITS'(largest_r) + 1'b1;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == ST_QUERY) && out_free;

  // new largest id from an incoming edge
  always_comb begin
    largest_nxt = largest_r;
    if (in_first_node > largest_nxt) begin
      largest_nxt = in_first_node;
    end
    if (in_second_node > largest_nxt) begin
      largest_nxt = in_second_node;
    end
  end

  // memory port: read issued on accept, write in the cycle after
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = id_addr(a_r);
    mem_req.wdata = deg_inc;
    mem_req.raddr = id_addr(q_r);
    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_cnt_r;
        mem_req.wdata = '0;
      end
      ST_IDLE: begin
        mem_req.raddr = (in_req_type == REQ_QUERY) ? id_addr(in_query_node)
                                                   : id_addr(in_first_node);
      end
      ST_UPD_A: begin
        mem_req.we    = id_in_store(a_r);
        mem_req.raddr = id_addr(b_r);
      end
      ST_UPD_B: begin
        // self-loop counts once
        mem_req.we    = id_in_store(b_r) && (b_r != a_r);
        mem_req.waddr = id_addr(b_r);
      end
      ST_QUERY: begin
        mem_req.raddr = id_addr(q_r);
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  // state, counters and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      largest_r   <= '0;
      edges_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result word handshake
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_BITS'(NODE_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            a_r <= in_first_node;
            b_r <= in_second_node;
            q_r <= in_query_node;
            if (in_req_type == REQ_ADD) begin
              largest_r <= largest_nxt;
              if (edges_r != '1) begin
                edges_r <= edges_r + 1'b1;
              end
              state_r <= ST_UPD_A;
            end else begin
              state_r <= ST_QUERY;
            end
          end
        end
        ST_UPD_A: begin
          state_r <= ST_UPD_B;
        end
        ST_UPD_B: begin
          state_r <= ST_IDLE;
        end
        ST_QUERY: begin
          // hold the read until the result register frees up
          if (out_load) begin
            out_degree_r <= id_in_store(q_r) ? report_degree(mem_rdata) : '0;
            out_total_r  <= total;
            out_edges_r  <= edges_r;
            out_range_r  <= (TOTAL_BITS'(q_r) < total);
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/edge_list_degree_counter.sv */
// Top level of the edge list degree counter: sequencer plus degree memory.
// Depends on eldc_pkg, eldc_seq and eldc_ram.
//
// Builds vertex degrees of an undirected graph from a stream of edge words.
// An add word (req_type 0) reads the first endpoint's degree on acceptance,
// then each endpoint gets a read-modify-write through the one write port of
// the degree memory, in states ST_UPD_A and ST_UPD_B. A query word
// (req_type 1) reads the degree, then loads the result register, waiting in
// ST_QUERY while the previous result has not been taken. Adds produce no result.
// After reset the degree memory is zeroed by a clearing pass over all
// NODE_DEPTH (1024) entries, during which in_ready stays low. Degrees and the
// edge count saturate; ids at or beyond NODE_DEPTH count toward node_total only.
module edge_list_degree_counter import eldc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [ID_BITS-1:0]    in_first_node,
  input  logic [ID_BITS-1:0]    in_second_node,
  input  logic [ID_BITS-1:0]    in_query_node,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COUNT_BITS-1:0] out_node_degree,
  output logic [TOTAL_BITS-1:0] out_node_total,
  output logic [COUNT_BITS-1:0] out_edge_total,
  output logic                  out_node_in_range
);

  mem_req_t               mem_req;
  logic [DEGREE_BITS-1:0] mem_rdata;

  eldc_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_first_node     (in_first_node),
    .in_second_node    (in_second_node),
    .in_query_node     (in_query_node),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_node_degree   (out_node_degree),
    .out_node_total    (out_node_total),
    .out_edge_total    (out_edge_total),
    .out_node_in_range (out_node_in_range),
    .mem_req           (mem_req),
    .mem_rdata         (mem_rdata)
  );

  // degree store
  eldc_ram #(
    .WIDTH (DEGREE_BITS),
    .DEPTH (NODE_DEPTH)
  ) u_deg_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

/* src/eldc_checker.sv */
// Port-level checker for edge_list_degree_counter, bound to the top level.
// Uses eldc_pkg.
module eldc_checker import eldc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COUNT_BITS-1:0] out_node_degree,
  input logic [TOTAL_BITS-1:0] out_node_total,
  input logic [COUNT_BITS-1:0] out_edge_total,
  input logic                  out_node_in_range
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node_degree)
      && $stable(out_node_total) && $stable(out_edge_total))
    else $error("result word changed while stalled");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // node count is never zero
  a_total_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_node_total != '0)
    else $error("node total of zero");

  // a node with edges has been seen, so it is in range
  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_node_degree != '0 |-> out_node_in_range)
    else $error("nonzero degree on node out of range");

  // each edge adds at most one to any degree
  a_deg_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_node_degree <= out_edge_total)
    else $error("degree exceeds edge count");

endmodule

bind edge_list_degree_counter eldc_checker u_eldc_checker (.*);
